### hdl/sopalu_pkg.sv
// shared types and constants for the single-operand alu
// no dependencies
`default_nettype none

package sopalu_pkg;

  // instruction codes as presented on the operation field
  typedef enum logic [3:0] {
    OP_CLRB = 4'd0,
    OP_COMB = 4'd1,
    OP_INCB = 4'd2,
    OP_DECB = 4'd3,
    OP_NEGB = 4'd4,
    OP_ADCB = 4'd5,
    OP_SBCB = 4'd6,
    OP_TSTB = 4'd7,
    OP_RORB = 4'd8,
    OP_ROLB = 4'd9,
    OP_ASRB = 4'd10,
    OP_ASLB = 4'd11,
    OP_ASL  = 4'd12,
    OP_MTPS = 4'd13,
    OP_MFPS = 4'd14,
    OP_SXT  = 4'd15
  } op_t;

  // status word bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_V = 1;
  localparam int FLAG_Z = 2;
  localparam int FLAG_N = 3;
  localparam int FLAG_T = 4;

  localparam logic [7:0] BYTE_MAX_POS = 8'o177;
  localparam logic [7:0] BYTE_MIN_NEG = 8'o200;
  localparam logic [7:0] BYTE_ALL_ONE = 8'o377;

  // everything one instruction produces
  typedef struct packed {
    logic [15:0] value;
    logic        write_en;
    logic        write_byte;
    logic [7:0]  status;
  } alu_res_t;

endpackage

`default_nettype wire

### hdl/sopalu_exec.sv
// combinational execute logic for one single-operand instruction
// depends on sopalu_pkg
`default_nettype none

module sopalu_exec (
  input  wire logic [3:0]          operation,
  input  wire logic [15:0]         operand,
  input  wire logic                operand_valid,
  input  wire logic                dest_is_register,
  input  wire logic [7:0]          status,
  output sopalu_pkg::alu_res_t     res
);
  import sopalu_pkg::*;

  always_comb begin
    logic [7:0]  st;
    logic [7:0]  src;
    logic [7:0]  r8;
    logic [15:0] r16;
    logic        cin;
    logic [15:0] val;
    logic        we;
    logic        wbyte;

    st    = status;
    src   = operand[7:0];
    cin   = status[FLAG_C];
    r8    = '0;
    r16   = '0;
    val   = '0;
    we    = 1'b0;
    wbyte = 1'b1;

    if (operand_valid) begin
      unique case (op_t'(operation))
        OP_CLRB: begin
          we = 1'b1;
          st[FLAG_N] = 1'b0;
          st[FLAG_Z] = 1'b1;
          st[FLAG_V] = 1'b0;
          st[FLAG_C] = 1'b0;
        end
        OP_COMB: begin
          r8 = ~src;
          we = 1'b1;
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
          st[FLAG_V] = 1'b0;
          st[FLAG_C] = 1'b1;
        end
        OP_INCB: begin
          r8 = src + 8'd1;
          we = 1'b1;
          st[FLAG_V] = (src == BYTE_MAX_POS);
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
        end
        OP_DECB: begin
          r8 = src - 8'd1;
          we = 1'b1;
          st[FLAG_V] = (src == BYTE_MIN_NEG);
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
        end
        OP_NEGB: begin
          r8 = 8'd0 - src;
          we = 1'b1;
          st[FLAG_V] = (r8 == BYTE_MIN_NEG);
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
          st[FLAG_C] = (r8 != 8'h00);
        end
        OP_ADCB: begin
          r8 = src + {7'd0, cin};
          we = 1'b1;
          st[FLAG_V] = (src == BYTE_MAX_POS) && cin;
          st[FLAG_C] = (src == BYTE_ALL_ONE) && cin;
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
        end
        OP_SBCB: begin
          r8 = src - {7'd0, cin};
          we = 1'b1;
          // overflow flag follows the operand alone, carry or not
          st[FLAG_V] = (src == BYTE_MIN_NEG);
          st[FLAG_C] = (src == 8'h00) && cin;
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
        end
        OP_TSTB: begin
          st[FLAG_V] = 1'b0;
          st[FLAG_C] = 1'b0;
          st[FLAG_N] = src[7];
          st[FLAG_Z] = (src == 8'h00);
        end
        OP_RORB: begin
          r8 = {cin, src[7:1]};
          we = 1'b1;
          st[FLAG_C] = src[0];
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
          st[FLAG_V] = r8[7] ^ src[0];
        end
        OP_ROLB: begin
          r8 = {src[6:0], cin};
          we = 1'b1;
          st[FLAG_C] = src[7];
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
          st[FLAG_V] = r8[7] ^ src[7];
        end
        OP_ASRB: begin
          r8 = {src[7], src[7:1]};
          we = 1'b1;
          st[FLAG_C] = src[0];
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
          st[FLAG_V] = r8[7] ^ src[0];
        end
        OP_ASLB: begin
          r8 = {src[6:0], 1'b0};
          we = 1'b1;
          st[FLAG_C] = src[7];
          st[FLAG_N] = r8[7];
          st[FLAG_Z] = (r8 == 8'h00);
          st[FLAG_V] = r8[7] ^ src[7];
        end
        OP_ASL: begin
          r16   = {operand[14:0], 1'b0};
          we    = 1'b1;
          wbyte = 1'b0;
          st[FLAG_C] = operand[15];
          st[FLAG_N] = r16[15];
          st[FLAG_Z] = (r16 == 16'h0000);
          st[FLAG_V] = r16[15] ^ operand[15];
        end
        OP_MTPS: begin
          // trace bit is not loadable here
          st = {src[7:5], status[FLAG_T], src[3:0]};
        end
        OP_MFPS: begin
          we = 1'b1;
          if (dest_is_register) begin
            r16   = {{8{status[7]}}, status};
            wbyte = 1'b0;
          end else begin
            r8 = status;
          end
          st[FLAG_N] = status[7];
          st[FLAG_Z] = (status == 8'h00);
          st[FLAG_V] = 1'b0;
        end
        OP_SXT: begin
          r16   = {16{status[FLAG_N]}};
          we    = 1'b1;
          wbyte = 1'b0;
          st[FLAG_Z] = ~status[FLAG_N];
          st[FLAG_V] = 1'b0;
        end
      endcase
    end

    val = wbyte ? {8'h00, r8} : r16;
    if (!we) begin
      val   = '0;
      wbyte = 1'b0;
    end

    res.value      = val;
    res.write_en   = we;
    res.write_byte = wbyte;
    res.status     = st;
  end

endmodule

`default_nettype wire

### hdl/pdp11_single_operand_alu_core.sv
// top level of the single-operand alu: input register, execute, result register
// depends on sopalu_pkg and sopalu_exec
// a result passes through the input register and then the result register
// throughput: one instruction per cycle while out_stall does not hold a full result stage
// reset: synchronous rst clears the status word and both stage valid flags
`default_nettype none

module pdp11_single_operand_alu_core (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  operation,
  input  wire logic [15:0] operand,
  input  wire logic        operand_valid,
  input  wire logic        dest_is_register,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      result_value,
  output logic             write_enable,
  output logic             write_is_byte,
  output logic [7:0]       status_out
);
  import sopalu_pkg::*;

  // input stage registers
  logic        in_full;
  logic [3:0]  op_q;
  logic [15:0] opnd_q;
  logic        ovalid_q;
  logic        dreg_q;

  // processor status word, architectural state
  logic [7:0]  status;

  // result stage registers
  logic        out_full;
  alu_res_t    res_q;

  alu_res_t    res;
  logic        advance;
  logic        in_xfer;

  // the input stage moves forward whenever the result slot is free or draining
  assign advance  = in_full && !(out_full && out_stall);
  // the input stage can take a new transfer if empty or emptying this cycle
  assign in_stall = in_full && !advance;
  assign in_xfer  = in_valid && !in_stall;

  sopalu_exec u_exec (
    .operation        (op_q),
    .operand          (opnd_q),
    .operand_valid    (ovalid_q),
    .dest_is_register (dreg_q),
    .status           (status),
    .res              (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_xfer) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q     <= operation;
      opnd_q   <= operand;
      ovalid_q <= operand_valid;
      dreg_q   <= dest_is_register;
    end
  end

  // status commits exactly when an instruction moves into the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else if (advance) begin
      status <= res.status;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid     = out_full;
  assign result_value  = res_q.value;
  assign write_enable  = res_q.write_en;
  assign write_is_byte = res_q.write_byte;
  assign status_out    = res_q.status;

endmodule

`default_nettype wire

### tb/pdp11_single_operand_alu_core_tb.sv
// self-checking bench for pdp11_single_operand_alu_core: directed and random instructions
// predicts each result and the status word in-bench; depends on sopalu_pkg and the core rtl
`timescale 1ns / 100ps

module pdp11_single_operand_alu_core_tb;
  import sopalu_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 12;   // margin after the last result is back
  localparam int IDLE_PCT     = 29;

  // one instruction as offered to the core, plus a bench-only drain marker
  typedef struct {
    op_t         operation;
    logic [15:0] operand;
    logic        opnd_ok;
    logic        dest_reg;
    logic        drain_first;   // hold this one back until every result is back
  } instr_t;

  logic        clk;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  op_t         operation = OP_CLRB;
  logic [15:0] operand = 16'h0000;
  logic        operand_valid = 1'b0;
  logic        dest_is_register = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] result_value;
  logic        write_enable;
  logic        write_is_byte;
  logic [7:0]  status_out;

  instr_t      pending_instr[$];     // instructions not yet offered
  alu_res_t    expected_results[$];  // predicted results in transfer order
  logic [7:0]  psw_model = 8'h00;    // predicted processor status word
  int          accepted_count = 0;
  int          err_count = 0;
  int          cycle_count = 0;
  logic        quiet_stretch = 1'b0; // no idling on either side while set

  pdp11_single_operand_alu_core u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .operand          (operand),
    .operand_valid    (operand_valid),
    .dest_is_register (dest_is_register),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_value     (result_value),
    .write_enable     (write_enable),
    .write_is_byte    (write_is_byte),
    .status_out       (status_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // single reset pulse at the start of the run
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // executes one instruction against psw_model and returns what the core should report
  function automatic alu_res_t exec_instr(input instr_t it);
    logic [7:0]  st;
    logic [7:0]  src;
    logic [7:0]  ps;
    logic [15:0] res;
    logic        cin;
    logic        we;
    logic        wbyte;
    logic        shift_op;
    alu_res_t    r;
    st       = psw_model;
    src      = it.operand[7:0];
    cin      = st[FLAG_C];
    res      = 16'h0000;
    we       = 1'b0;
    wbyte    = 1'b1;
    shift_op = 1'b0;
    // a failed access touches neither the destination nor the status
    if (it.opnd_ok) begin
      case (it.operation)
        OP_CLRB: begin
          we = 1'b1;
          st[FLAG_N] = 1'b0;
          st[FLAG_V] = 1'b0;
          st[FLAG_C] = 1'b0;
          st[FLAG_Z] = 1'b1;
        end
        OP_COMB: begin
          res[7:0] = ~src;
          we = 1'b1;
          st[FLAG_V] = 1'b0;
          st[FLAG_C] = 1'b1;
        end
        OP_INCB: begin
          res[7:0] = src + 8'd1;
          we = 1'b1;
          st[FLAG_V] = (src == BYTE_MAX_POS);
        end
        OP_DECB: begin
          res[7:0] = src - 8'd1;
          we = 1'b1;
          st[FLAG_V] = (src == BYTE_MIN_NEG);
        end
        OP_NEGB: begin
          res[7:0] = 8'd0 - src;
          we = 1'b1;
          st[FLAG_V] = (res[7:0] == BYTE_MIN_NEG);
          st[FLAG_C] = (res[7:0] != 8'd0);
        end
        OP_ADCB: begin
          res[7:0] = src + {7'd0, cin};
          we = 1'b1;
          st[FLAG_V] = (src == BYTE_MAX_POS) && cin;
          st[FLAG_C] = (src == BYTE_ALL_ONE) && cin;
        end
        OP_SBCB: begin
          res[7:0] = src - {7'd0, cin};
          we = 1'b1;
          st[FLAG_V] = (src == BYTE_MIN_NEG);
          st[FLAG_C] = (src == 8'd0) && cin;
        end
        OP_TSTB: begin
          // flags from the source, nothing written
          res[7:0] = src;
          st[FLAG_V] = 1'b0;
          st[FLAG_C] = 1'b0;
        end
        OP_RORB: begin
          res[7:0] = {cin, src[7:1]};
          we = 1'b1;
          st[FLAG_C] = src[0];
          shift_op = 1'b1;
        end
        OP_ROLB: begin
          res[7:0] = {src[6:0], cin};
          we = 1'b1;
          st[FLAG_C] = src[7];
          shift_op = 1'b1;
        end
        OP_ASRB: begin
          res[7:0] = {src[7], src[7:1]};
          we = 1'b1;
          st[FLAG_C] = src[0];
          shift_op = 1'b1;
        end
        OP_ASLB: begin
          res[7:0] = {src[6:0], 1'b0};
          we = 1'b1;
          st[FLAG_C] = src[7];
          shift_op = 1'b1;
        end
        OP_ASL: begin
          res = {it.operand[14:0], 1'b0};
          we = 1'b1;
          wbyte = 1'b0;
          st[FLAG_C] = it.operand[15];
        end
        OP_MTPS: begin
          // trace bit keeps its value
          st = (st & (8'd1 << FLAG_T)) | (src & ~(8'd1 << FLAG_T));
        end
        OP_MFPS: begin
          ps = st;
          we = 1'b1;
          if (it.dest_reg) begin
            res = {{8{ps[7]}}, ps};
            wbyte = 1'b0;
          end else begin
            res = {8'h00, ps};
          end
        end
        default: begin
          // sxt
          res = st[FLAG_N] ? 16'hFFFF : 16'h0000;
          we = 1'b1;
          wbyte = 1'b0;
          st[FLAG_Z] = ~st[FLAG_N];
          st[FLAG_V] = 1'b0;
        end
      endcase
      // n and z for everything that derives them from a result
      case (it.operation)
        OP_COMB, OP_INCB, OP_DECB, OP_NEGB, OP_ADCB, OP_SBCB, OP_TSTB,
        OP_RORB, OP_ROLB, OP_ASRB, OP_ASLB, OP_MFPS: begin
          st[FLAG_N] = res[7];
          st[FLAG_Z] = (res[7:0] == 8'd0);
        end
        OP_ASL: begin
          st[FLAG_N] = res[15];
          st[FLAG_Z] = (res == 16'd0);
          shift_op = 1'b1;
        end
        default: ;
      endcase
      if (it.operation == OP_MFPS) st[FLAG_V] = 1'b0;
      if (shift_op) st[FLAG_V] = st[FLAG_N] ^ st[FLAG_C];
    end
    psw_model = st;
    if (!we) begin
      res = 16'h0000;
      wbyte = 1'b0;
    end
    r.value      = res;
    r.write_en   = we;
    r.write_byte = wbyte;
    r.status     = st;
    return r;
  endfunction

  task automatic add_instr(input op_t op, input logic [15:0] opnd, input logic ok,
                           input logic is_reg);
    instr_t it;
    it = '{op, opnd, ok, is_reg, 1'b0};
    pending_instr.push_back(it);
  endtask

  // driver: records the prediction on each input transfer, then offers the next item
  always @(posedge clk) begin : driver
    instr_t nxt;
    logic   fire;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        expected_results.push_back(
          exec_instr('{operation, operand, operand_valid, dest_is_register, 1'b0}));
        accepted_count++;
      end
      quiet_stretch <= (accepted_count >= 300) && (accepted_count < 500);
      // payload only moves once the current one has been taken
      if (!in_valid || fire) begin
        if (pending_instr.size() != 0 &&
            !(pending_instr[0].drain_first && expected_results.size() != 0) &&
            (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_instr.pop_front();
          operation        <= nxt.operation;
          operand          <= nxt.operand;
          operand_valid    <= nxt.opnd_ok;
          dest_is_register <= nxt.dest_reg;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each output transfer with the oldest prediction
  always @(posedge clk) begin : monitor
    alu_res_t want;
    alu_res_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{result_value, write_enable, write_is_byte, status_out};
        if (expected_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: value %h we %b byte %b status %h",
                   $realtime, got.value, got.write_en, got.write_byte, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: mismatch: expected value %h we %b byte %b status %h, got value %h we %b byte %b status %h",
                     $realtime, want.value, want.write_en, want.write_byte, want.status,
                     got.value, got.write_en, got.write_byte, got.status);
          end
        end
      end
      out_stall <= !quiet_stretch && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin : stimulus
    instr_t      it;
    logic [7:0]  corner;
    // directed part: set every status bit but the trace bit, then walk every instruction's edge cases
    add_instr(OP_MTPS, 16'h00FF, 1'b1, 1'b0);  // trace bit must stay clear
    add_instr(OP_MFPS, 16'h0000, 1'b1, 1'b1);  // negative status, sign extended
    add_instr(OP_MFPS, 16'hFFFF, 1'b1, 1'b0);  // byte write to memory
    add_instr(OP_SXT,  16'h1234, 1'b1, 1'b0);  // n set gives all ones
    add_instr(OP_ADCB, 16'hFFFF, 1'b1, 1'b0);  // carry in on 0377 wraps
    add_instr(OP_ADCB, 16'h007F, 1'b1, 1'b1);  // overflow into 0200
    add_instr(OP_MTPS, 16'h0001, 1'b1, 1'b0);
    add_instr(OP_SBCB, 16'h0000, 1'b1, 1'b0);  // borrow out of zero
    add_instr(OP_SBCB, 16'h0080, 1'b1, 1'b0);
    add_instr(OP_NEGB, 16'h0080, 1'b1, 1'b0);
    add_instr(OP_NEGB, 16'h0000, 1'b1, 1'b0);
    add_instr(OP_INCB, 16'h007F, 1'b1, 1'b0);
    add_instr(OP_DECB, 16'h0080, 1'b1, 1'b0);
    add_instr(OP_COMB, 16'hFF00, 1'b1, 1'b0);
    add_instr(OP_CLRB, 16'hFFFF, 1'b1, 1'b0);
    add_instr(OP_TSTB, 16'h0080, 1'b1, 1'b0);
    add_instr(OP_RORB, 16'h0001, 1'b1, 1'b0);
    add_instr(OP_ROLB, 16'h0080, 1'b1, 1'b0);
    add_instr(OP_ASRB, 16'h0081, 1'b1, 1'b0);
    add_instr(OP_ASLB, 16'h00C0, 1'b1, 1'b0);
    add_instr(OP_ASL,  16'h8000, 1'b1, 1'b0);
    add_instr(OP_ASL,  16'h7FFF, 1'b1, 1'b0);
    add_instr(OP_MTPS, 16'h0000, 1'b1, 1'b0);
    add_instr(OP_SXT,  16'hFFFF, 1'b1, 1'b1);  // n clear gives zero
    add_instr(OP_MFPS, 16'h0000, 1'b1, 1'b1);  // status with only z set, to a register
    // failed accesses leave everything alone
    add_instr(OP_CLRB, 16'hFFFF, 1'b0, 1'b1);
    add_instr(OP_MFPS, 16'hFFFF, 1'b0, 1'b1);
    add_instr(OP_MTPS, 16'hFFFF, 1'b0, 1'b0);

    // random part: mostly good accesses, corner bytes mixed in
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      it.operation = op_t'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: corner = 8'h00;
          1: corner = BYTE_MAX_POS;
          2: corner = BYTE_MIN_NEG;
          default: corner = BYTE_ALL_ONE;
        endcase
        it.operand = {8'($urandom_range(0, 255)), corner};
      end else begin
        it.operand = 16'($urandom);
      end
      it.opnd_ok     = ($urandom_range(0, 9) != 0);
      it.dest_reg    = 1'($urandom_range(0, 1));
      it.drain_first = (i == 0) || (i == RANDOM_ITEMS / 2);
      pending_instr.push_back(it);
    end

    // all offered, all taken, all results back, then a short tail
    while (pending_instr.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog on the cycle counter
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
hdl/sopalu_pkg.sv
hdl/sopalu_exec.sv
hdl/pdp11_single_operand_alu_core.sv
tb/pdp11_single_operand_alu_core_tb.sv
